@@ rtl/stwf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stwf_pkg: shared types and constants of the sine tone generator
// Request and result payloads, the command codes and the fixed number
// formats used by the core, the sine ROM and the port checker.
// ----------------------------------------------------------------------------
package stwf_pkg;

	localparam int unsigned SAMPLE_RATE_HZ   = 16000;
	localparam int unsigned FADE_SAMPLES     = 80;
	localparam int unsigned SINE_TABLE_DEPTH = 4096;
	localparam int unsigned SAMPLES_PER_MS   = SAMPLE_RATE_HZ / 1000;

	localparam int unsigned VOLUME_W     = 7;
	localparam int unsigned VOLUME_RESET = 70;
	localparam int unsigned VOLUME_MAX   = 100;

	localparam int unsigned FREQ_W   = 16;
	localparam int unsigned DUR_W    = 16;
	localparam int unsigned SAMPLE_W = 15;
	localparam int unsigned LEN_W    = 21;

	// Table index = phase * 4096 / 16000 = (phase * 32) / 125.
	localparam int unsigned IDX_SHIFT = 5;
	localparam int unsigned IDX_DEN   = SAMPLE_RATE_HZ / 128;
	localparam int unsigned IDX_W     = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned REM_W     = $clog2(IDX_DEN);
	localparam int unsigned STEP_W    = $clog2(SAMPLE_RATE_HZ);
	localparam int unsigned DVD_W     = STEP_W + IDX_SHIFT;

	// One quarter wave of the table, both end points included.
	localparam int unsigned QUARTER     = SINE_TABLE_DEPTH / 4;
	localparam int unsigned QTR_W       = $clog2(QUARTER);
	localparam int unsigned SINE_ADDR_W = QTR_W + 1;
	localparam int unsigned MAG_W       = 15;

	// 120 * volume * w * s / (80 * 32768) reduces to 3 * volume * w * s / 65536.
	localparam int unsigned SCALE_NUM   = 3;
	localparam int unsigned SCALE_SHIFT = 16;
	localparam int unsigned WEIGHT_W    = $clog2(FADE_SAMPLES + 1);
	localparam int unsigned COEF_W      = 15;
	localparam int unsigned RES_W       = 14;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_TICK  = 1'b1
	} command_t;

	typedef struct packed {
		command_t          command;
		logic [FREQ_W-1:0] freq_hz;
		logic [DUR_W-1:0]  duration_ms;
	} request_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       active;
		logic                       note_last;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/stwf_sine_rom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stwf_sine_rom: quarter-wave sine ROM
// Holds round(32768 * sin(pi/2 * a / 1024)) saturated to 32767 for every
// quarter-wave address a, built at elaboration; the read data is registered.
// ----------------------------------------------------------------------------
module stwf_sine_rom
	import stwf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic [SINE_ADDR_W-1:0] addr,
	output logic      [MAG_W-1:0]       data
);

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [MAG_W-1:0] sine_tab_t [0:QUARTER];

	function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r);
		longint unsigned x;
		longint unsigned term;
		longint unsigned q;
		longint          sum;
		int unsigned     n;
		x = (HALF_PI_Q30 * 64'(r)) / 64'(SINE_TABLE_DEPTH);
		term = x;
		sum = longint'(x);
		for (n = 1; n <= 7; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if (n[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		q = (longint'(sum) + 64'd16384) >> 15;
		if (q > 64'd32767)
			q = 64'd32767;
		return MAG_W'(q);
	endfunction

	function automatic sine_tab_t build_tab();
		sine_tab_t tab;
		for (int a = 0; a <= QUARTER; a++)
			tab[a] = quarter_sine(4 * a);
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_tab();

	always_ff @(posedge clk) begin
		data <= SINE_TAB[addr];
	end

endmodule
`default_nettype wire

@@ rtl/sine_tone_with_fade_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sine_tone_with_fade_core: sine tone generator with linear fade
// A start request loads a note; each tick request returns one signed sample
// with a 5 ms linear fade in and fade out.
// ----------------------------------------------------------------------------
// The block handles one request at a time. A tick request passes from
// acceptance, which also reads the sine ROM, through a state that loads the
// multiplier and the serial multiplier, which retires two bits of the sine
// magnitude per cycle, to a state that writes the output register. A tick
// with no note playing goes from acceptance straight to that last state.
// Either tick path waits in its last state for as long as the previous
// sample still waits unread in the output register. A start request passes
// from acceptance through a reduction of the frequency modulo the sample
// rate and a bit-serial divider that splits the phase step into a table
// index step and a remainder. Results wait in an output register, so the
// next request is taken while a sample is still waiting to be read. The
// volume register is written through cfg_we and cfg_wdata.
// ----------------------------------------------------------------------------
module sine_tone_with_fade_core
	import stwf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire request_t            req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output result_t                  rsp,
	input  wire logic                cfg_we,
	input  wire logic [VOLUME_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_DIV,
		ST_LOAD,
		ST_MUL,
		ST_DONE
	} state_t;

	localparam int unsigned CNT_W     = $clog2(DVD_W);
	localparam int unsigned MUL_STEPS = (MAG_W + 1) / 2;
	localparam int unsigned P_LO_W    = 2 * MUL_STEPS;
	localparam int unsigned P_HI_W    = COEF_W + 2;
	localparam int unsigned P_W       = P_HI_W + P_LO_W;

	state_t                  state_q;
	logic [VOLUME_W-1:0]     vol_q;
	logic [LEN_W-1:0]        len_q;
	logic [LEN_W-1:0]        k_q;
	logic                    active_q;
	logic [IDX_W-1:0]        idx_q;
	logic [REM_W-1:0]        rem_q;
	logic [IDX_W-1:0]        q_step_q;
	logic [REM_W-1:0]        r_step_q;
	logic [FREQ_W-1:0]       step_q;
	logic [DVD_W-1:0]        dvd_q;
	logic [REM_W-1:0]        drem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [COEF_W-1:0]       coef_q;
	logic [P_W-1:0]          p_q;
	logic                    neg_q;
	logic                    res_active_q;
	logic                    res_last_q;
	logic                    rsp_valid_q;
	result_t                 rsp_q;

	logic                    req_fire;
	logic [LEN_W-1:0]        len_next;
	logic                    tick_live;
	logic                    tick_last;
	logic [VOLUME_W-1:0]     vol_sat;
	logic [WEIGHT_W-1:0]     weight;
	logic [COEF_W-1:0]       coef_next;
	logic [REM_W:0]          rem_sum;
	logic                    rem_carry;
	logic [REM_W-1:0]        rem_next;
	logic [IDX_W-1:0]        idx_next;
	logic [REM_W:0]          div_trial;
	logic                    div_bit;
	logic [REM_W-1:0]        drem_next;
	logic [DVD_W-1:0]        dvd_next;
	logic [SINE_ADDR_W-1:0]  rom_addr;
	logic [MAG_W-1:0]        rom_data;
	logic [P_HI_W-1:0]       digit_prod;
	logic [P_HI_W:0]         mul_sum;
	logic [P_W:0]            mul_cat;
	logic [RES_W-1:0]        res_mag;
	logic [SAMPLE_W-1:0]     res_ext;

	stwf_sine_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		len_next  = LEN_W'(req.duration_ms) * LEN_W'(SAMPLES_PER_MS);
		tick_live = active_q && (k_q < len_q);
		tick_last = ((k_q + LEN_W'(1)) == len_q);
		vol_sat   = (vol_q > VOLUME_W'(VOLUME_MAX)) ? VOLUME_W'(VOLUME_MAX) : vol_q;

		if (k_q < LEN_W'(FADE_SAMPLES)) begin
			weight = k_q[WEIGHT_W-1:0];
		end else if ((len_q > LEN_W'(FADE_SAMPLES)) &&
			(({1'b0, k_q} + (LEN_W+1)'(FADE_SAMPLES)) > {1'b0, len_q})) begin
			weight = WEIGHT_W'(len_q - k_q);
		end else begin
			weight = WEIGHT_W'(FADE_SAMPLES);
		end
		coef_next = COEF_W'(SCALE_NUM) * COEF_W'(vol_sat) * COEF_W'(weight);

		rem_sum   = {1'b0, rem_q} + {1'b0, r_step_q};
		rem_carry = (rem_sum >= (REM_W+1)'(IDX_DEN));
		rem_next  = rem_carry ? REM_W'(rem_sum - (REM_W+1)'(IDX_DEN)) : rem_sum[REM_W-1:0];
		idx_next  = idx_q + q_step_q + IDX_W'(rem_carry);

		div_trial = {drem_q, dvd_q[DVD_W-1]};
		div_bit   = (div_trial >= (REM_W+1)'(IDX_DEN));
		drem_next = div_bit ? REM_W'(div_trial - (REM_W+1)'(IDX_DEN)) : div_trial[REM_W-1:0];
		dvd_next  = {dvd_q[DVD_W-2:0], div_bit};

		if (idx_q[QTR_W])
			rom_addr = SINE_ADDR_W'(QUARTER) - {1'b0, idx_q[QTR_W-1:0]};
		else
			rom_addr = {1'b0, idx_q[QTR_W-1:0]};

		digit_prod = P_HI_W'(coef_q) * P_HI_W'(p_q[1:0]);
		mul_sum    = {1'b0, p_q[P_W-1:P_LO_W]} + {1'b0, digit_prod};
		mul_cat    = {mul_sum, p_q[P_LO_W-1:0]};

		res_mag = p_q[SCALE_SHIFT+RES_W-1:SCALE_SHIFT];
		res_ext = {{(SAMPLE_W-RES_W){1'b0}}, res_mag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vol_q        <= VOLUME_W'(VOLUME_RESET);
			len_q        <= '0;
			k_q          <= '0;
			active_q     <= 1'b0;
			idx_q        <= '0;
			rem_q        <= '0;
			q_step_q     <= '0;
			r_step_q     <= '0;
			step_q       <= '0;
			dvd_q        <= '0;
			drem_q       <= '0;
			cnt_q        <= '0;
			coef_q       <= '0;
			p_q          <= '0;
			neg_q        <= 1'b0;
			res_active_q <= 1'b0;
			res_last_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (cfg_we)
				vol_q <= cfg_wdata;
			if (rsp_valid_q && rsp_ready && (state_q != ST_DONE))
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.command == CMD_START)) begin
						len_q    <= len_next;
						k_q      <= '0;
						idx_q    <= '0;
						rem_q    <= '0;
						active_q <= (len_next != '0);
						step_q   <= req.freq_hz;
						state_q  <= ST_MOD;
					end else if (req_fire) begin
						if (tick_live) begin
							coef_q       <= coef_next;
							neg_q        <= idx_q[IDX_W-1];
							res_active_q <= 1'b1;
							res_last_q   <= tick_last;
							k_q          <= k_q + LEN_W'(1);
							idx_q        <= idx_next;
							rem_q        <= rem_next;
							if (tick_last)
								active_q <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							active_q     <= 1'b0;
							p_q          <= '0;
							neg_q        <= 1'b0;
							res_active_q <= 1'b0;
							res_last_q   <= 1'b0;
							state_q      <= ST_DONE;
						end
					end
				end
				ST_MOD: begin
					if (step_q >= FREQ_W'(SAMPLE_RATE_HZ)) begin
						step_q <= step_q - FREQ_W'(SAMPLE_RATE_HZ);
					end else begin
						dvd_q   <= {step_q[STEP_W-1:0], {IDX_SHIFT{1'b0}}};
						drem_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					dvd_q  <= dvd_next;
					drem_q <= drem_next;
					cnt_q  <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DVD_W - 1)) begin
						q_step_q <= dvd_next[IDX_W-1:0];
						r_step_q <= drem_next;
						state_q  <= ST_IDLE;
					end
				end
				ST_LOAD: begin
					p_q     <= {{(P_W-MAG_W){1'b0}}, rom_data};
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					p_q   <= {1'b0, mul_cat[P_W:2]};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MUL_STEPS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q     <= 1'b1;
						rsp_q.sample    <= neg_q ? -res_ext : res_ext;
						rsp_q.active    <= res_active_q;
						rsp_q.note_last <= res_last_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/stwf_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stwf_checker: port checker for the sine tone generator
// Watches the request and result ports of the core over time.
// ----------------------------------------------------------------------------
module stwf_checker
	import stwf_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    req_valid,
	input wire logic    req_ready,
	input wire logic    rsp_valid,
	input wire logic    rsp_ready,
	input wire result_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is in progress");

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.sample >= -15'sd12000) && (rsp.sample <= 15'sd12000))
		else $error("sample outside the amplitude range");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.active |-> (rsp.sample == '0) && !rsp.note_last)
		else $error("tick without a note is not silent");

endmodule

bind sine_tone_with_fade_core stwf_checker u_stwf_checker (.*);
`default_nettype wire

@@ sim/tb_sine_tone_with_fade_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sine_tone_with_fade_core: self-checking bench for the sine tone core
// Feeds start and tick requests through the valid/ready port with random
// gaps and output stalls. A bit-exact tone predictor builds the expected
// samples, and each returned sample is checked in order against them. The
// volume is changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_sine_tone_with_fade_core;
	import stwf_pkg::*;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int unsigned PEAK_PER_PERCENT = 120;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 1600;
	localparam int unsigned PHASES = 7;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	request_t            req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	result_t             rsp;
	logic                cfg_we = 1'b0;
	logic [VOLUME_W-1:0] cfg_wdata = '0;

	request_t pending_requests[$];
	result_t  expected_samples[$];
	bit       req_taken = 1'b0;
	bit       steady_flow = 1'b0;
	int unsigned req_gap = 0;
	int unsigned stall_left = 0;
	int unsigned stuck_cycles = 0;
	int unsigned mismatch_count = 0;
	int unsigned volume_plan[PHASES] = '{100, 0, 127, 1, 99, 101, 50};

	// Tone state as the core should hold it.
	logic [VOLUME_W-1:0] tone_volume = VOLUME_RESET;
	logic [FREQ_W-1:0]   tone_freq = '0;
	logic [LEN_W-1:0]    tone_length = '0;
	logic [LEN_W-1:0]    tone_index = '0;
	logic [15:0]         tone_phase = '0;
	logic                tone_on = 1'b0;

	sine_tone_with_fade_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic bit tone_predict(request_t r, output result_t res);
		longint unsigned x, term, mag, prod, amp, tidx, q4, quad, rem;
		longint signed acc;
		int unsigned w, vol, n;
		res = '0;
		if (r.command == CMD_START) begin
			tone_freq = r.freq_hz;
			tone_length = LEN_W'((longint'(SAMPLE_RATE_HZ) * r.duration_ms) / 1000);
			tone_index = '0;
			tone_phase = '0;
			tone_on = (tone_length != 0);
			return 1'b0;
		end
		if (!tone_on || tone_index >= tone_length) begin
			tone_on = 1'b0;
			return 1'b1;
		end
		res.active = 1'b1;
		res.note_last = (tone_index + 1 == tone_length);
		if (tone_freq != 0) begin
			vol = (tone_volume > VOLUME_MAX) ? VOLUME_MAX : tone_volume;
			if (tone_index < FADE_SAMPLES)
				w = tone_index;
			else if (tone_length > FADE_SAMPLES && tone_index > tone_length - FADE_SAMPLES)
				w = tone_length - tone_index;
			else
				w = FADE_SAMPLES;
			// Quarter-wave fold of the table index, then a Q30 Taylor series.
			tidx = longint'(tone_phase) * SINE_TABLE_DEPTH / SAMPLE_RATE_HZ;
			q4 = tidx * 4;
			quad = q4 / SINE_TABLE_DEPTH;
			rem = q4 - quad * SINE_TABLE_DEPTH;
			if (quad[0])
				rem = SINE_TABLE_DEPTH - rem;
			x = HALF_PI_Q30 * rem / SINE_TABLE_DEPTH;
			term = x;
			acc = x;
			for (n = 1; n <= 7; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / ((2 * n) * (2 * n + 1));
				if (n % 2)
					acc = acc - term;
				else
					acc = acc + term;
			end
			if (acc < 0)
				acc = 0;
			mag = ($unsigned(acc) + 16384) >> 15;
			if (mag > 32767)
				mag = 32767;
			prod = PEAK_PER_PERCENT * vol * w * mag;
			amp = prod / (FADE_SAMPLES * 32768);
			res.sample = SAMPLE_W'(quad[1] ? -amp : amp);
		end
		tone_index = tone_index + 1'b1;
		tone_phase = tone_phase + tone_freq % SAMPLE_RATE_HZ;
		if (tone_phase >= SAMPLE_RATE_HZ)
			tone_phase = tone_phase - SAMPLE_RATE_HZ;
		if (res.note_last)
			tone_on = 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [FREQ_W-1:0] pick_freq();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return 16'd1;
			2: return 16'd8000;
			3: return 16'd16000;
			4: return 16'd65535;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic void push_start(logic [FREQ_W-1:0] f, logic [DUR_W-1:0] d);
		request_t r;
		r.command = CMD_START;
		r.freq_hz = f;
		r.duration_ms = d;
		pending_requests.push_back(r);
	endfunction

	function automatic void push_ticks(int unsigned count);
		request_t r;
		repeat (count) begin
			r.command = CMD_TICK;
			r.freq_hz = 16'($urandom_range(0, 65535));
			r.duration_ms = 16'($urandom_range(0, 65535));
			pending_requests.push_back(r);
		end
	endfunction

	function automatic void check_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic add_random_items(int unsigned count);
		int unsigned added, dur, ticks, r;
		request_t noise;
		added = 0;
		while (added < count) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				// Whole note played out, with up to two ticks past its end.
				dur = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 7);
				ticks = dur * SAMPLES_PER_MS + $urandom_range(0, 2);
				push_start(pick_freq(), DUR_W'(dur));
				push_ticks(ticks);
				added += ticks + 1;
			end else if (r < 88) begin
				// Note of any length, given between one and 40 ticks before the next start.
				ticks = $urandom_range(1, 40);
				push_start(pick_freq(), DUR_W'($urandom_range(0, 65535)));
				push_ticks(ticks);
				added += ticks + 1;
			end else begin
				noise.command = command_t'($urandom_range(0, 1));
				noise.freq_hz = 16'($urandom_range(0, 65535));
				noise.duration_ms = 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
					: $urandom_range(0, 3));
				pending_requests.push_back(noise);
				added++;
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || req_valid || expected_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_volume(logic [VOLUME_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		tone_volume = v;
	endtask

	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (req_gap != 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				req <= pending_requests.pop_front();
				req_valid <= 1'b1;
				req_gap = pick_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		result_t predicted;
		req_taken = arst_n && req_valid && req_ready;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				if (tone_predict(req, predicted))
					expected_samples.push_back(predicted);
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected sample, expected none, got %0d/%0b/%0b",
						$time, rsp.sample, rsp.active, rsp.note_last);
					mismatch_count++;
				end else begin
					predicted = expected_samples.pop_front();
					check_field("sample", predicted.sample, rsp.sample);
					check_field("active", predicted.active, rsp.active);
					check_field("note_last", predicted.note_last, rsp.note_last);
				end
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_ticks(1);
		push_start(16'hFFFF, 16'd0);
		push_ticks(1);
		push_start(16'd0, 16'd1);
		push_ticks(1);
		push_start(16'd16000, 16'd1);
		push_ticks(1);
		push_start(16'd4000, 16'hFFFF);
		push_ticks(3);
		push_start(16'hFFFF, 16'd1);
		push_ticks(17);

		volume_plan[PHASES-1] = $urandom_range(0, 127);
		foreach (volume_plan[p]) begin
			write_volume(VOLUME_W'(volume_plan[p]));
			steady_flow = ($urandom_range(0, 3) == 0);
			add_random_items(RANDOM_ITEMS / PHASES);
		end

		wait_idle();
		if (mismatch_count == 0 && expected_samples.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
